### rtl/complex_arithmetic_unit_macros.svh
// Assertion helpers for the complex arithmetic unit.
// Each macro expects clk_i and rst_ni in scope.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication.
`define CAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("complex_arithmetic_unit: assertion failed");

// Next-cycle implication.
`define CAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("complex_arithmetic_unit: assertion failed");

`endif

### rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and saturation helpers of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 16;

  typedef logic signed [WordBits-1:0] word_t;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MAG = 4'd4,
    OP_LT  = 4'd5,
    OP_GT  = 4'd6,
    OP_LE  = 4'd7,
    OP_GE  = 4'd8,
    OP_EQ  = 4'd9,
    OP_NE  = 4'd10
  } op_e;

  typedef enum logic [2:0] {
    CLS_ADD,
    CLS_SUB,
    CLS_MUL,
    CLS_DIV,
    CLS_MAG,
    CLS_CMP,
    CLS_EQ,
    CLS_NONE
  } cls_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DZ  = 2'd1,
    ST_SAT = 2'd2
  } status_e;

  typedef struct packed {
    cls_e  cls;
    op_e   op;
    word_t ar;
    word_t ai;
    word_t br;
    word_t bi;
  } item_t;

  typedef struct packed {
    word_t val;
    logic  sat;
  } sat_t;

  // Clamp a sign/magnitude value to the signed word range.
  function automatic sat_t sat_mag(input logic neg, input logic ovf,
                                   input logic [WordBits-1:0] mag);
    logic [WordBits-1:0] lim;
    sat_t r;
    lim = neg ? {1'b1, {(WordBits-1){1'b0}}} : {1'b0, {(WordBits-1){1'b1}}};
    if (ovf || (mag > lim)) begin
      r.val = lim;
      r.sat = 1'b1;
    end else begin
      r.val = neg ? (~mag + 1'b1) : mag;
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // Clamp a sum that grew by one bit.
  function automatic sat_t sat_sum(input logic [WordBits:0] s);
    sat_t r;
    r.sat = s[WordBits] != s[WordBits-1];
    if (r.sat) begin
      r.val = s[WordBits] ? {1'b1, {(WordBits-1){1'b0}}} : {1'b0, {(WordBits-1){1'b1}}};
    end else begin
      r.val = s[WordBits-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Streaming complex ALU on signed Q16.16 operands.
// ----------------------------------------------------------------------------
// Input channel s_axis: one transaction carries an opcode in tuser and the two
// complex operands in tdata. Output channel m_axis: one transaction per input
// transaction, in order, with both result parts in tdata and the compare flag
// and status in tuser.
// Opcodes: add, sub, mul, div (a * conj(b) / |b|^2), magnitude of a, the four
// magnitude compares, equal and not equal. Saturated results report status 2,
// a zero divisor gives 0+0j and status 1.
// Every opcode runs through the same pipeline. Throughput: one transaction per
// cycle while the output is not stalled.
// The fixed depth comes from the 32 divide/root steps, one quotient bit and
// one root bit per stage, after a multiply stage and a combine stage.
// A two-entry queue sits between the input stage and the pipeline.
// When m_axis_tready_i is low while m_axis holds a result, the pipeline holds;
// the input keeps accepting until the queue and input register are full.
// Reset clears all valid bits; no transaction is in flight afterwards.
`default_nettype none

`include "complex_arithmetic_unit_macros.svh"

module complex_arithmetic_unit (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // a_real, a_imag, b_real, b_imag
  input  wire  [127:0] s_axis_tdata_i,
  // req_type
  input  wire  [3:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  // result_real, result_imag
  output logic [63:0]  m_axis_tdata_o,
  // compare_true, status
  output logic [2:0]   m_axis_tuser_o
);

  cau_pkg::item_t   f_item, q_item;
  logic             f_vld, q_full, q_empty, b_rdy;
  cau_pkg::word_t   res_real, res_imag;
  logic             cmp;
  cau_pkg::status_e status;

  cau_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_data_i  (s_axis_tdata_i),
    .s_op_i    (s_axis_tuser_i),
    .item_o    (f_item),
    .vld_o     (f_vld),
    .rdy_i     (!q_full)
  );

  cau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_vld),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (b_rdy),
    .item_o  (q_item),
    .empty_o (q_empty)
  );

  cau_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (q_item),
    .vld_i      (!q_empty),
    .rdy_o      (b_rdy),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .res_real_o (res_real),
    .res_imag_o (res_imag),
    .cmp_o      (cmp),
    .status_o   (status)
  );

  assign m_axis_tdata_o = {res_imag, res_real};
  assign m_axis_tuser_o = {status, cmp};

  `CAU_ASSERT_IMP(a_cmp_zero_data, m_axis_tvalid_o && cmp, m_axis_tdata_o == '0)
  `CAU_ASSERT_IMP(a_dz_zero_data, m_axis_tvalid_o && status == cau_pkg::ST_DZ,
                  m_axis_tdata_o == '0 && !cmp)
  `CAU_ASSERT_IMP(a_stall_front_full, !s_axis_tready_o, f_vld && q_full)
  `CAU_ASSERT_NXT(a_full_holds, q_full && !b_rdy, q_full)

endmodule

`default_nettype wire

### rtl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Input stage: accepts a transaction, unpacks operands and classifies opcode.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_valid_i,
  output logic                s_ready_o,
  input  wire  [127:0]        s_data_i,
  input  wire  [3:0]          s_op_i,
  output cau_pkg::item_t      item_o,
  output logic                vld_o,
  input  wire                 rdy_i
);

  logic           vld_q, vld_d;
  cau_pkg::item_t item_q, item_d;
  cau_pkg::op_e   op;

  assign op        = cau_pkg::op_e'(s_op_i);
  assign s_ready_o = !vld_q || rdy_i;

  always_comb begin
    item_d.op = op;
    item_d.ar = s_data_i[31:0];
    item_d.ai = s_data_i[63:32];
    item_d.br = s_data_i[95:64];
    item_d.bi = s_data_i[127:96];
    unique case (op)
      cau_pkg::OP_ADD: item_d.cls = cau_pkg::CLS_ADD;
      cau_pkg::OP_SUB: item_d.cls = cau_pkg::CLS_SUB;
      cau_pkg::OP_MUL: item_d.cls = cau_pkg::CLS_MUL;
      cau_pkg::OP_DIV: item_d.cls = cau_pkg::CLS_DIV;
      cau_pkg::OP_MAG: item_d.cls = cau_pkg::CLS_MAG;
      cau_pkg::OP_LT, cau_pkg::OP_GT,
      cau_pkg::OP_LE, cau_pkg::OP_GE: item_d.cls = cau_pkg::CLS_CMP;
      cau_pkg::OP_EQ, cau_pkg::OP_NE: item_d.cls = cau_pkg::CLS_EQ;
      default:         item_d.cls = cau_pkg::CLS_NONE;
    endcase
    vld_d = s_ready_o ? s_valid_i : vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;
  assign vld_o  = vld_q;

endmodule

`default_nettype wire

### rtl/cau_queue.sv
// ----------------------------------------------------------------------------
// cau_queue
// Two-entry queue between the front and the execution pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  cau_pkg::item_t  item_i,
  output logic            full_o,
  input  wire             pop_i,
  output cau_pkg::item_t  item_o,
  output logic            empty_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  cau_pkg::item_t       mem_q [Depth];
  logic [PtrW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]        cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = cnt_q == (PtrW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

### rtl/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// Execution pipeline: products, combine, 32 divide/root steps, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  cau_pkg::item_t      item_i,
  input  wire                 vld_i,
  output logic                rdy_o,
  output logic                m_valid_o,
  input  wire                 m_ready_i,
  output cau_pkg::word_t      res_real_o,
  output cau_pkg::word_t      res_imag_o,
  output logic                cmp_o,
  output cau_pkg::status_e    status_o
);

  localparam int unsigned Steps = cau_pkg::WordBits;

  typedef struct packed {
    cau_pkg::cls_e  cls;
    cau_pkg::op_e   op;
    cau_pkg::word_t ar, ai, br, bi;
    logic [63:0]    p_rr, p_ii, p_ri, p_ir;
    logic [63:0]    s_ar, s_ai, s_br, s_bi;
  } mstg_t;

  typedef struct packed {
    cau_pkg::cls_e    cls;
    cau_pkg::status_e st;
    cau_pkg::word_t   rr, ri;
    logic             cmp;
    logic             neg_r, neg_i, ovf_r, ovf_i;
    logic [63:0]      den;
    logic [63:0]      rem_r, rem_i;
    logic [31:0]      nl_r, nl_i, q_r, q_i;
    logic [63:0]      rem_s;
    logic [31:0]      root;
  } wstg_t;

  logic    adv;
  logic    m_vld_q;
  mstg_t   m_q, m_d;
  logic    w_vld_q [Steps+1];
  wstg_t   w_q [Steps+1];
  wstg_t   w_d [Steps+1];
  logic    out_vld_q;
  cau_pkg::word_t   out_rr_q, out_ri_q, out_rr_d, out_ri_d;
  logic             out_cmp_q;
  cau_pkg::status_e out_st_q, out_st_d;

  // Whole pipeline moves together when the output register can take a result.
  assign adv   = !out_vld_q || m_ready_i;
  assign rdy_o = adv;

  // Products stage
  always_comb begin
    m_d.cls  = item_i.cls;
    m_d.op   = item_i.op;
    m_d.ar   = item_i.ar;
    m_d.ai   = item_i.ai;
    m_d.br   = item_i.br;
    m_d.bi   = item_i.bi;
    m_d.p_rr = $signed(item_i.ar) * $signed(item_i.br);
    m_d.p_ii = $signed(item_i.ai) * $signed(item_i.bi);
    m_d.p_ri = $signed(item_i.ar) * $signed(item_i.bi);
    m_d.p_ir = $signed(item_i.ai) * $signed(item_i.br);
    m_d.s_ar = $signed(item_i.ar) * $signed(item_i.ar);
    m_d.s_ai = $signed(item_i.ai) * $signed(item_i.ai);
    m_d.s_br = $signed(item_i.br) * $signed(item_i.br);
    m_d.s_bi = $signed(item_i.bi) * $signed(item_i.bi);
  end

  // Combine stage
  logic [32:0] sum_r, sum_i, dif_r, dif_i;
  logic [64:0] mr, mi, dr, di;
  logic [63:0] mr_mag, mi_mag, dr_mag, di_mag;
  logic [63:0] sa, sb;
  cau_pkg::sat_t sr, si;

  always_comb begin
    w_d[0] = '0;
    w_d[0].cls = m_q.cls;
    w_d[0].st  = cau_pkg::ST_OK;

    sum_r = {m_q.ar[31], m_q.ar} + {m_q.br[31], m_q.br};
    sum_i = {m_q.ai[31], m_q.ai} + {m_q.bi[31], m_q.bi};
    dif_r = {m_q.ar[31], m_q.ar} - {m_q.br[31], m_q.br};
    dif_i = {m_q.ai[31], m_q.ai} - {m_q.bi[31], m_q.bi};

    mr = {m_q.p_rr[63], m_q.p_rr} - {m_q.p_ii[63], m_q.p_ii};
    mi = {m_q.p_ri[63], m_q.p_ri} + {m_q.p_ir[63], m_q.p_ir};
    dr = {m_q.p_rr[63], m_q.p_rr} + {m_q.p_ii[63], m_q.p_ii};
    di = {m_q.p_ir[63], m_q.p_ir} - {m_q.p_ri[63], m_q.p_ri};
    mr_mag = mr[64] ? 64'(~mr + 1'b1) : mr[63:0];
    mi_mag = mi[64] ? 64'(~mi + 1'b1) : mi[63:0];
    dr_mag = dr[64] ? 64'(~dr + 1'b1) : dr[63:0];
    di_mag = di[64] ? 64'(~di + 1'b1) : di[63:0];

    sa = m_q.s_ar + m_q.s_ai;
    sb = m_q.s_br + m_q.s_bi;

    sr = '0;
    si = '0;
    case (m_q.cls)
      cau_pkg::CLS_ADD: begin
        sr = cau_pkg::sat_sum(sum_r);
        si = cau_pkg::sat_sum(sum_i);
      end
      cau_pkg::CLS_SUB: begin
        sr = cau_pkg::sat_sum(dif_r);
        si = cau_pkg::sat_sum(dif_i);
      end
      cau_pkg::CLS_MUL: begin
        // Drop fraction bits of the magnitude: truncation toward zero.
        sr = cau_pkg::sat_mag(mr[64], |mr_mag[63:48], mr_mag[47:16]);
        si = cau_pkg::sat_mag(mi[64], |mi_mag[63:48], mi_mag[47:16]);
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase
    w_d[0].rr = sr.val;
    w_d[0].ri = si.val;
    if (sr.sat || si.sat) begin
      w_d[0].st = cau_pkg::ST_SAT;
    end

    case (m_q.cls)
      cau_pkg::CLS_CMP: begin
        case (m_q.op)
          cau_pkg::OP_LT: w_d[0].cmp = sa < sb;
          cau_pkg::OP_GT: w_d[0].cmp = sa > sb;
          cau_pkg::OP_LE: w_d[0].cmp = sa <= sb;
          default:        w_d[0].cmp = sa >= sb;
        endcase
      end
      cau_pkg::CLS_EQ: begin
        w_d[0].cmp = ((m_q.ar == m_q.br) && (m_q.ai == m_q.bi)) ==
                     (m_q.op == cau_pkg::OP_EQ);
      end
      default: w_d[0].cmp = 1'b0;
    endcase

    // Divide: numerator magnitude shifted by the fraction width; the upper
    // part seeds the remainder, a quotient that would pass 32 bits saturates.
    w_d[0].den   = sb;
    w_d[0].neg_r = dr[64];
    w_d[0].neg_i = di[64];
    w_d[0].ovf_r = {16'b0, dr_mag[63:16]} >= sb;
    w_d[0].ovf_i = {16'b0, di_mag[63:16]} >= sb;
    w_d[0].rem_r = {16'b0, dr_mag[63:16]};
    w_d[0].rem_i = {16'b0, di_mag[63:16]};
    w_d[0].nl_r  = {dr_mag[15:0], 16'b0};
    w_d[0].nl_i  = {di_mag[15:0], 16'b0};
    if ((m_q.cls == cau_pkg::CLS_DIV) && (sb == '0)) begin
      w_d[0].st = cau_pkg::ST_DZ;
    end

    w_d[0].rem_s = sa;
    w_d[0].root  = '0;
  end

  // One quotient bit per divider and one root bit per stage.
  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int unsigned Bit = Steps - 1 - k;
    logic [64:0] tr, ti;
    logic        ge_r, ge_i, ge_s;
    logic [65:0] trial;

    always_comb begin
      w_d[k+1] = w_q[k];
      tr   = {w_q[k].rem_r, w_q[k].nl_r[31]};
      ti   = {w_q[k].rem_i, w_q[k].nl_i[31]};
      ge_r = tr >= {1'b0, w_q[k].den};
      ge_i = ti >= {1'b0, w_q[k].den};
      w_d[k+1].rem_r = ge_r ? 64'(tr - {1'b0, w_q[k].den}) : tr[63:0];
      w_d[k+1].rem_i = ge_i ? 64'(ti - {1'b0, w_q[k].den}) : ti[63:0];
      w_d[k+1].nl_r  = {w_q[k].nl_r[30:0], 1'b0};
      w_d[k+1].nl_i  = {w_q[k].nl_i[30:0], 1'b0};
      w_d[k+1].q_r   = {w_q[k].q_r[30:0], ge_r};
      w_d[k+1].q_i   = {w_q[k].q_i[30:0], ge_i};

      trial = ({34'b0, w_q[k].root} << (Bit + 1)) | (66'd1 << (2 * Bit));
      ge_s  = {2'b0, w_q[k].rem_s} >= trial;
      if (ge_s) begin
        w_d[k+1].rem_s = 64'({2'b0, w_q[k].rem_s} - trial);
        w_d[k+1].root  = w_q[k].root | (32'd1 << Bit);
      end
    end
  end

  // Final selection
  cau_pkg::sat_t fr, fi;
  always_comb begin
    out_rr_d = w_q[Steps].rr;
    out_ri_d = w_q[Steps].ri;
    out_st_d = w_q[Steps].st;
    fr = cau_pkg::sat_mag(w_q[Steps].neg_r, w_q[Steps].ovf_r, w_q[Steps].q_r);
    fi = cau_pkg::sat_mag(w_q[Steps].neg_i, w_q[Steps].ovf_i, w_q[Steps].q_i);
    if (w_q[Steps].cls == cau_pkg::CLS_DIV && w_q[Steps].st != cau_pkg::ST_DZ) begin
      out_rr_d = fr.val;
      out_ri_d = fi.val;
      out_st_d = (fr.sat || fi.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end else if (w_q[Steps].cls == cau_pkg::CLS_MAG) begin
      fr = cau_pkg::sat_mag(1'b0, 1'b0, w_q[Steps].root);
      out_rr_d = fr.val;
      out_ri_d = '0;
      out_st_d = fr.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i <= Steps; i++) begin
        w_vld_q[i] <= 1'b0;
      end
    end else if (adv) begin
      m_vld_q    <= vld_i;
      w_vld_q[0] <= m_vld_q;
      for (int i = 0; i < Steps; i++) begin
        w_vld_q[i+1] <= w_vld_q[i];
      end
      out_vld_q  <= w_vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q <= m_d;
      for (int i = 0; i <= Steps; i++) begin
        w_q[i] <= w_d[i];
      end
      out_rr_q  <= out_rr_d;
      out_ri_q  <= out_ri_d;
      out_cmp_q <= w_q[Steps].cmp;
      out_st_q  <= out_st_d;
    end
  end

  assign m_valid_o  = out_vld_q;
  assign res_real_o = out_rr_q;
  assign res_imag_o = out_ri_q;
  assign cmp_o      = out_cmp_q;
  assign status_o   = out_st_q;

endmodule

`default_nettype wire

### tb/sv/tb_complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Self-checking testbench for the streaming complex ALU.
// ----------------------------------------------------------------------------
// Drives opcode and operand transactions on s_axis, predicts each result with
// a behavioral model of the fixed-point arithmetic, and compares every m_axis
// transaction in order. Directed corner cases come first, then random traffic
// under four settings of the send and receive idle percentages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit;

  localparam int unsigned PipeDepth = 37;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        cmp;
    logic [1:0]  status;
  } alu_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;
  logic [3:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [63:0]  m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;

  alu_result_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  complex_arithmetic_unit DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o),
    .m_axis_tuser_o(m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Clamp a wide signed value to the word range.
  function automatic logic [31:0] clamp_word(input logic signed [127:0] v,
                                             inout logic [1:0] st);
    if (v > 128'sd2147483647) begin
      st = cau_pkg::ST_SAT;
      return 32'h7fffffff;
    end
    if (v < -128'sd2147483648) begin
      st = cau_pkg::ST_SAT;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // Divide truncating toward zero.
  function automatic logic signed [127:0] div_trunc(input logic signed [127:0] n,
                                                    input logic signed [127:0] d);
    logic [127:0] q;
    q = (n < 0 ? -n : n) / d;
    return n < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 49; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= n) r = t;
    end
    return r;
  endfunction

  function automatic alu_result_t compute_complex(input logic [3:0] op,
      input logic signed [31:0] ar, input logic signed [31:0] ai,
      input logic signed [31:0] br, input logic signed [31:0] bi);
    alu_result_t r;
    logic signed [127:0] xr, xi, yr, yi, nr, ni, den, mag_a;
    logic [1:0] st;
    xr = ar; xi = ai; yr = br; yi = bi;
    st = cau_pkg::ST_OK;
    r = '0;
    den = yr * yr + yi * yi;
    mag_a = xr * xr + xi * xi;
    case (op)
      cau_pkg::OP_ADD: begin
        r.re = clamp_word(xr + yr, st);
        r.im = clamp_word(xi + yi, st);
      end
      cau_pkg::OP_SUB: begin
        r.re = clamp_word(xr - yr, st);
        r.im = clamp_word(xi - yi, st);
      end
      cau_pkg::OP_MUL: begin
        nr = xr * yr - xi * yi;
        ni = xr * yi + xi * yr;
        r.re = clamp_word(div_trunc(nr, 128'sd65536), st);
        r.im = clamp_word(div_trunc(ni, 128'sd65536), st);
      end
      cau_pkg::OP_DIV: begin
        if (den == 0) begin
          st = cau_pkg::ST_DZ;
        end else begin
          nr = (xr * yr + xi * yi) * 128'sd65536;
          ni = (xi * yr - xr * yi) * 128'sd65536;
          r.re = clamp_word(div_trunc(nr, den), st);
          r.im = clamp_word(div_trunc(ni, den), st);
        end
      end
      cau_pkg::OP_MAG: r.re = clamp_word($signed({64'd0, floor_sqrt(mag_a)}), st);
      cau_pkg::OP_LT: r.cmp = mag_a < den;
      cau_pkg::OP_GT: r.cmp = mag_a > den;
      cau_pkg::OP_LE: r.cmp = mag_a <= den;
      cau_pkg::OP_GE: r.cmp = mag_a >= den;
      cau_pkg::OP_EQ: r.cmp = (ar == br) && (ai == bi);
      cau_pkg::OP_NE: r.cmp = (ar != br) || (ai != bi);
      default: ;
    endcase
    r.status = st;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Ready depends on registers only, so the value seen at the falling edge
  // is the one that the next rising edge uses.
  task automatic send_op(input logic [3:0] op, input logic [31:0] ar,
                         input logic [31:0] ai, input logic [31:0] br,
                         input logic [31:0] bi);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {bi, br, ai, ar};
    @(negedge clk_i);
    while (!s_axis_tready_o) @(negedge clk_i);
    @(posedge clk_i);
    expected_results.push_back(compute_complex(op, ar, ai, br, bi));
  endtask

  // Check at the falling edge: the output registers and tready hold their
  // values until the rising edge that accepts the transaction.
  always @(negedge clk_i) begin
    alu_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata_o[31:0], '0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata_o[31:0] !== want.re)
          report_mismatch("result_real", m_axis_tdata_o[31:0], want.re);
        if (m_axis_tdata_o[63:32] !== want.im)
          report_mismatch("result_imag", m_axis_tdata_o[63:32], want.im);
        if (m_axis_tuser_o[0] !== want.cmp)
          report_mismatch("compare_true", m_axis_tuser_o[0], want.cmp);
        if (m_axis_tuser_o[2:1] !== want.status)
          report_mismatch("status", m_axis_tuser_o[2:1], want.status);
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      1: return $urandom_range(1) ? 32'h0 : 32'hffffffff;
      2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    for (int op = 0; op <= 10; op++) send_op(4'(op), mx, mn, mx, mn);
    send_op(cau_pkg::OP_ADD, mx, mx, 32'd1, 32'd1);
    send_op(cau_pkg::OP_SUB, mn, mn, 32'd1, 32'd1);
    send_op(cau_pkg::OP_MUL, mn, mn, mn, mn);
    send_op(cau_pkg::OP_MUL, 32'h00018000, 32'hfffe0000, 32'h00020000, 32'h00008000);
    send_op(cau_pkg::OP_DIV, 32'h00010000, 32'h00010000, 32'd0, 32'd0);
    send_op(cau_pkg::OP_DIV, mx, mx, 32'd1, 32'd0);
    send_op(cau_pkg::OP_DIV, 32'hfffd0000, 32'h00010000, 32'h00020000, 32'hffff0000);
    send_op(cau_pkg::OP_MAG, mn, mn, 32'd0, 32'd0);
    send_op(cau_pkg::OP_MAG, 32'h00030000, 32'h00040000, 32'd0, 32'd0);
    send_op(cau_pkg::OP_LT, 32'h00030000, 32'h00040000, 32'h00040000, 32'h00030000);
    send_op(cau_pkg::OP_GE, 32'h00030000, 32'h00040000, 32'hfffc0000, 32'h00030000);
    send_op(4'd11, mx, mx, mx, mx);
    send_op(4'd15, mn, mn, mn, mn);
    drain_results();
  endtask

  task automatic test_random(input int unsigned count, input int unsigned s_idle,
                             input int unsigned r_idle);
    logic [31:0] ar, ai, br, bi;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int n = 0; n < count; n++) begin
      ar = rand_word(); ai = rand_word(); br = rand_word(); bi = rand_word();
      // make equality and equal magnitudes show up often
      if ($urandom_range(9) == 0) begin br = ar; bi = ai; end
      if ($urandom_range(19) == 0) begin br = ai; bi = ar; end
      if ($urandom_range(19) == 0) begin br = 0; bi = 0; end
      send_op(4'($urandom_range(15)), ar, ai, br, bi);
    end
  endtask

  task automatic test_pause_until_empty();
    test_random(20, 0, 30);
    drain_results();
    test_random(20, 0, 0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    recv_idle_pct = 46;
    send_idle_pct = 23;
    test_directed();
    test_random(360, 23, 46);
    test_random(360, 46, 23);
    test_pause_until_empty();
    test_random(340, 0, 0);
    drain_results();
    repeat (PipeDepth + 10) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
